>>> design/u2c_pkg.sv
// Shared types and constants for the UTF-8 to CP1251 converter.
// No dependencies; used by every module of the block.
package u2c_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_TRIPLE = 2'd2
    } phase_t;

    // one accepted byte yields up to three copies of one character, then maybe a terminator
    typedef struct packed {
        logic [7:0] chr;
        logic [1:0] cnt;
        logic       term;
    } result_set_t;

    localparam int         CFG_INDEX_W      = 4;
    localparam logic [3:0] REG_OUT_CAPACITY = 4'd0;
    localparam logic [3:0] REG_REPLACE_CHAR = 4'd1;

    localparam int          CAP_REG_W        = 13;
    localparam logic [12:0] CAP_RESET        = 13'd256;
    localparam logic [7:0]  REPLACE_RESET    = 8'd42;

    localparam logic [7:0] LEAD_D0      = 8'hD0;
    localparam logic [7:0] LEAD_D1      = 8'hD1;
    localparam logic [7:0] LEAD_C2      = 8'hC2;
    localparam logic [7:0] LEAD_E2      = 8'hE2;
    localparam logic [7:0] OFFSET_D0    = 8'h30;
    localparam logic [7:0] OFFSET_D1    = 8'h70;
    localparam logic [7:0] SEC_YO_UPPER = 8'h81;
    localparam logic [7:0] CP_YO_UPPER  = 8'hA8;
    localparam logic [7:0] SEC_YO_LOWER = 8'h91;
    localparam logic [7:0] CP_YO_LOWER  = 8'hB8;
    localparam logic [7:0] SEC_E2_80    = 8'h80;
    localparam logic [7:0] THIRD_DASH   = 8'h94;
    localparam logic [7:0] THIRD_DOTS   = 8'hA6;
    localparam logic [7:0] GUILLEMET_L  = 8'hAB;
    localparam logic [7:0] GUILLEMET_R  = 8'hBB;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;

endpackage

>>> design/u2c_decoder.sv
// Sequence decoder: holds the message state and turns one accepted byte into a result set.
// Depends on u2c_pkg.
module u2c_decoder #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 in_byte,
    input  logic                       msg_end,
    input  logic [u2c_pkg::CAP_REG_W-1:0] out_capacity,
    input  logic [7:0]                 replace_char,
    output u2c_pkg::result_set_t       result
);

    localparam int CNT_W  = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
    localparam int MAXC_W = $clog2(MAX_CAPACITY + 1);
    localparam int CW     = ((MAXC_W > u2c_pkg::CAP_REG_W) ? MAXC_W : u2c_pkg::CAP_REG_W) + 1;
    localparam logic [CW-1:0] MAX_CAP = CW'(MAX_CAPACITY);

    u2c_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       lead_reg, lead_next;
    logic [7:0]       second_reg, second_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             finished_reg, finished_next;

    logic [7:0]    req_chr;
    logic [1:0]    req_cnt;
    logic [1:0]    grant_cnt;
    logic [CW-1:0] cap;
    logic [CW-1:0] cap1;
    logic [CW-1:0] avail;
    logic [CW-1:0] count_ext;

    // requested characters for the current byte
    always_comb
    begin
        req_chr = replace_char;
        req_cnt = 2'd0;
        unique case (phase_reg)
            u2c_pkg::PH_IDLE:
            begin
                req_chr = in_byte;
                req_cnt = in_byte[7] ? 2'd0 : 2'd1;
            end
            u2c_pkg::PH_LEAD:
            begin
                req_cnt = 2'd1;
                if (lead_reg == u2c_pkg::LEAD_D0)
                begin
                    if (in_byte >= 8'h90 && in_byte < 8'hD0)
                        req_chr = in_byte + u2c_pkg::OFFSET_D0;
                    else if (in_byte == u2c_pkg::SEC_YO_UPPER)
                        req_chr = u2c_pkg::CP_YO_UPPER;
                    else
                        req_chr = in_byte;
                end
                else if (lead_reg == u2c_pkg::LEAD_D1)
                begin
                    if (in_byte >= 8'h80 && in_byte < 8'h90)
                        req_chr = in_byte + u2c_pkg::OFFSET_D1;
                    else if (in_byte == u2c_pkg::SEC_YO_LOWER)
                        req_chr = u2c_pkg::CP_YO_LOWER;
                    else
                        req_chr = in_byte;
                end
                else if (lead_reg == u2c_pkg::LEAD_C2)
                begin
                    if (in_byte == u2c_pkg::GUILLEMET_L || in_byte == u2c_pkg::GUILLEMET_R)
                        req_chr = u2c_pkg::CHAR_QUOTE;
                end
                else if (lead_reg == u2c_pkg::LEAD_E2)
                begin
                    req_cnt = 2'd0;
                end
            end
            u2c_pkg::PH_TRIPLE:
            begin
                req_cnt = 2'd1;
                if (second_reg == u2c_pkg::SEC_E2_80 && in_byte == u2c_pkg::THIRD_DASH)
                begin
                    req_chr = u2c_pkg::CHAR_DASH;
                    req_cnt = 2'd2;
                end
                else if (second_reg == u2c_pkg::SEC_E2_80 && in_byte == u2c_pkg::THIRD_DOTS)
                begin
                    req_chr = u2c_pkg::CHAR_DOT;
                    req_cnt = 2'd3;
                end
            end
            default:
            begin
                req_cnt = 2'd0;
            end
        endcase
    end

    // clip to the room left in the output buffer
    always_comb
    begin
        cap = CW'(out_capacity);
        if (cap == '0)
            cap = CW'(1);
        if (cap > MAX_CAP)
            cap = MAX_CAP;
        cap1      = cap - CW'(1);
        count_ext = CW'(count_reg);
        avail     = (count_ext < cap1) ? (cap1 - count_ext) : '0;
        grant_cnt = (avail < CW'(req_cnt)) ? avail[1:0] : req_cnt;
    end

    // result set
    always_comb
    begin
        result.chr  = req_chr;
        result.cnt  = 2'd0;
        result.term = 1'b0;
        if (!finished_reg)
        begin
            if (in_byte == 8'd0)
            begin
                result.term = 1'b1;
            end
            else
            begin
                result.cnt  = grant_cnt;
                result.term = msg_end;
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        lead_next     = lead_reg;
        second_next   = second_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        if (finished_reg)
        begin
            if (msg_end)
            begin
                finished_next = 1'b0;
                phase_next    = u2c_pkg::PH_IDLE;
                count_next    = '0;
            end
        end
        else if (in_byte == 8'd0)
        begin
            phase_next    = u2c_pkg::PH_IDLE;
            count_next    = '0;
            finished_next = !msg_end;
        end
        else
        begin
            count_next = count_reg + CNT_W'(grant_cnt);
            unique case (phase_reg)
                u2c_pkg::PH_IDLE:
                begin
                    if (in_byte[7])
                    begin
                        lead_next  = in_byte;
                        phase_next = u2c_pkg::PH_LEAD;
                    end
                end
                u2c_pkg::PH_LEAD:
                begin
                    if (lead_reg == u2c_pkg::LEAD_E2)
                    begin
                        second_next = in_byte;
                        phase_next  = u2c_pkg::PH_TRIPLE;
                    end
                    else
                    begin
                        phase_next = u2c_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = u2c_pkg::PH_IDLE;
                end
            endcase
            if (msg_end)
            begin
                phase_next = u2c_pkg::PH_IDLE;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= u2c_pkg::PH_IDLE;
            lead_reg     <= 8'd0;
            second_reg   <= 8'd0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            lead_reg     <= lead_next;
            second_reg   <= second_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

endmodule

>>> design/u2c_out_queue.sv
// Expansion register and output register: drains a result set one byte per transfer.
// Depends on u2c_pkg.
module u2c_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  u2c_pkg::result_set_t set_in,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,  // [7:0] out_byte
    output logic                 m_tlast   // out_last
);

    logic [7:0] chr_reg;
    logic [1:0] rem_reg, rem_next;
    logic       term_reg, term_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       olast_reg, olast_next;

    logic exp_busy;
    logic exp_single;
    logic out_free;
    logic move;

    assign exp_busy   = (rem_reg != 2'd0) || term_reg;
    assign exp_single = (rem_reg == 2'd1 && !term_reg) || (rem_reg == 2'd0 && term_reg);
    assign out_free   = !ovalid_reg || m_tready;
    assign move       = exp_busy && out_free;
    assign can_load   = !exp_busy || (exp_single && out_free);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;

    always_comb
    begin
        rem_next    = rem_reg;
        term_next   = term_reg;
        ovalid_next = ovalid_reg && !m_tready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (move)
        begin
            ovalid_next = 1'b1;
            if (rem_reg != 2'd0)
            begin
                obyte_next = chr_reg;
                olast_next = 1'b0;
                rem_next   = rem_reg - 2'd1;
            end
            else
            begin
                obyte_next = 8'd0;
                olast_next = 1'b1;
                term_next  = 1'b0;
            end
        end
        if (load)
        begin
            rem_next  = set_in.cnt;
            term_next = set_in.term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= 2'd0;
            term_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            term_reg   <= term_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            chr_reg <= set_in.chr;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule

>>> design/utf8_to_cp1251_converter.sv
// Top level of the UTF-8 to CP1251 converter: configuration registers, decoder, output queue.
// Depends on u2c_pkg, u2c_decoder and u2c_out_queue.
//
// Converts a UTF-8 byte stream (s_tdata, message end on s_tlast) into CP1251 bytes on the
// master side, closing each message with a zero byte flagged by m_tlast. A byte is taken every
// cycle while it yields at most one result and the master side does not stall; a byte that
// yields more results (dash pair, three dots, or a character plus the terminator) holds s_tready
// low while the expansion register drains through the output register, one byte per transfer. A
// byte may be taken while the previous result still waits in the output register. Configuration
// writes are always taken (cfg_ready is high); indexes beyond the two registers are ignored.
module utf8_to_cp1251_converter #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] in_byte
    input  logic                             s_tlast,   // msg_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,   // out_last
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [u2c_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [u2c_pkg::CAP_REG_W-1:0]    cfg_data
);

    logic [u2c_pkg::CAP_REG_W-1:0] capacity_reg;
    logic [7:0]                    replace_reg;
    u2c_pkg::result_set_t          set;
    logic                          accept;
    logic                          can_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_load;
    assign accept    = s_tvalid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= u2c_pkg::CAP_RESET;
            replace_reg  <= u2c_pkg::REPLACE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == u2c_pkg::REG_OUT_CAPACITY)
                capacity_reg <= cfg_data;
            else if (cfg_index == u2c_pkg::REG_REPLACE_CHAR)
                replace_reg <= cfg_data[7:0];
        end
    end

    u2c_decoder #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (s_tdata),
        .msg_end      (s_tlast),
        .out_capacity (capacity_reg),
        .replace_char (replace_reg),
        .result       (set)
    );

    u2c_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .set_in   (set),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> test/utf8_to_cp1251_converter_test.sv
// Self-checking testbench for utf8_to_cp1251_converter: streams UTF-8 messages in, checks CP1251 out.
// Depends on u2c_pkg and the converter RTL; a built-in transcoder model predicts every output byte.
`timescale 1ns / 1ps

module utf8_to_cp1251_converter_test;

    localparam int         CAP_MAX     = 4096;
    localparam int         LONG_HOLD   = 300;
    localparam int         SETTLE      = 10;
    localparam logic [3:0] REG_UNUSED  = 4'd15;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_xfer_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [u2c_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [u2c_pkg::CAP_REG_W-1:0]   cfg_data;

    byte_xfer_t utf8_pending[$];
    byte_xfer_t cp1251_expected[$];

    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned pushed_count;
    int unsigned accepted_count;
    int unsigned emitted_count;
    int unsigned write_count;
    int unsigned err_count;
    int unsigned stall_reqs;
    int unsigned stall_ack;
    int unsigned hold_left;
    bit          in_taken;

    logic [12:0]     cap_reg;
    logic [7:0]      repl_reg;
    u2c_pkg::phase_t conv_phase;
    logic [7:0]      conv_lead;
    logic [7:0]      conv_second;
    int unsigned     conv_count;
    bit              conv_finished;

    utf8_to_cp1251_converter #(
        .MAX_CAPACITY(CAP_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic emit_char(input logic [7:0] c);
        int unsigned cap;
        cap = {19'd0, cap_reg};
        if (cap == 0)
            cap = 1;
        if (cap > CAP_MAX)
            cap = CAP_MAX;
        if (conv_count < cap - 1)
        begin
            cp1251_expected.push_back({c, 1'b0});
            conv_count++;
        end
    endtask

    task automatic close_msg();
        cp1251_expected.push_back({8'h00, 1'b1});
        conv_phase = u2c_pkg::PH_IDLE;
        conv_count = 0;
    endtask

    task automatic transcode_byte(input logic [7:0] b, input logic msg_end);
        if (conv_finished)
        begin
            if (msg_end)
            begin
                conv_finished = 0;
                conv_phase    = u2c_pkg::PH_IDLE;
                conv_count    = 0;
            end
        end
        else if (b == 8'h00)
        begin
            close_msg();
            conv_finished = !msg_end;
        end
        else
        begin
            case (conv_phase)
                u2c_pkg::PH_IDLE:
                begin
                    if (b < 8'h80)
                        emit_char(b);
                    else
                    begin
                        conv_lead  = b;
                        conv_phase = u2c_pkg::PH_LEAD;
                    end
                end
                u2c_pkg::PH_LEAD:
                begin
                    conv_phase = u2c_pkg::PH_IDLE;
                    if (conv_lead == u2c_pkg::LEAD_D0)
                    begin
                        if (b >= 8'h90 && b < 8'hD0)
                            emit_char(b + u2c_pkg::OFFSET_D0);
                        else if (b == u2c_pkg::SEC_YO_UPPER)
                            emit_char(u2c_pkg::CP_YO_UPPER);
                        else
                            emit_char(b);
                    end
                    else if (conv_lead == u2c_pkg::LEAD_D1)
                    begin
                        if (b >= 8'h80 && b < 8'h90)
                            emit_char(b + u2c_pkg::OFFSET_D1);
                        else if (b == u2c_pkg::SEC_YO_LOWER)
                            emit_char(u2c_pkg::CP_YO_LOWER);
                        else
                            emit_char(b);
                    end
                    else if (conv_lead == u2c_pkg::LEAD_C2)
                    begin
                        if (b == u2c_pkg::GUILLEMET_L || b == u2c_pkg::GUILLEMET_R)
                            emit_char(u2c_pkg::CHAR_QUOTE);
                        else
                            emit_char(repl_reg);
                    end
                    else if (conv_lead == u2c_pkg::LEAD_E2)
                    begin
                        conv_second = b;
                        conv_phase  = u2c_pkg::PH_TRIPLE;
                    end
                    else
                        emit_char(repl_reg);
                end
                default:
                begin
                    conv_phase = u2c_pkg::PH_IDLE;
                    if (conv_second == u2c_pkg::SEC_E2_80 && b == u2c_pkg::THIRD_DASH)
                    begin
                        emit_char(u2c_pkg::CHAR_DASH);
                        emit_char(u2c_pkg::CHAR_DASH);
                    end
                    else if (conv_second == u2c_pkg::SEC_E2_80 && b == u2c_pkg::THIRD_DOTS)
                    begin
                        emit_char(u2c_pkg::CHAR_DOT);
                        emit_char(u2c_pkg::CHAR_DOT);
                        emit_char(u2c_pkg::CHAR_DOT);
                    end
                    else
                        emit_char(repl_reg);
                end
            endcase
            if (msg_end)
            begin
                close_msg();
                conv_finished = 0;
            end
        end
    endtask

    // sender: hold each byte until its transfer, then advance or idle
    always @(negedge clk)
    begin
        byte_xfer_t nxt;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (utf8_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = utf8_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_reqs != stall_ack)
        begin
            stall_ack = stall_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        byte_xfer_t exp_x;
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
        begin
            accepted_count++;
            transcode_byte(s_tdata, s_tlast);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            emitted_count++;
            if (cp1251_expected.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %02h out_last %0b", m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                exp_x = cp1251_expected.pop_front();
                if (m_tdata !== exp_x.data)
                begin
                    $error("out_byte expected %02h actual %02h", exp_x.data, m_tdata);
                    err_count++;
                end
                if (m_tlast !== exp_x.last)
                begin
                    $error("out_last expected %0b actual %0b", exp_x.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic push_xfer(input logic [7:0] b, input logic msg_end);
        utf8_pending.push_back({b, msg_end});
        pushed_count++;
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == u2c_pkg::REG_OUT_CAPACITY)
            cap_reg = val;
        else if (idx == u2c_pkg::REG_REPLACE_CHAR)
            repl_reg = val[7:0];
        write_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (accepted_count != pushed_count || cp1251_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic gen_message(input int unsigned n_chars);
        logic [7:0]  seq[$];
        int unsigned k;
        seq = {};
        for (k = 0; k < n_chars; k++)
        begin
            case ($urandom_range(11))
                0, 1: seq.push_back(8'($urandom_range(8'h7F, 8'h01)));
                2:
                begin
                    seq.push_back(u2c_pkg::LEAD_D0);
                    seq.push_back(8'($urandom_range(8'hCF, 8'h90)));
                end
                3:
                begin
                    seq.push_back(u2c_pkg::LEAD_D0);
                    seq.push_back($urandom_range(1) ? u2c_pkg::SEC_YO_UPPER
                                                    : 8'($urandom_range(255)));
                end
                4:
                begin
                    seq.push_back(u2c_pkg::LEAD_D1);
                    seq.push_back(8'($urandom_range(8'h8F, 8'h80)));
                end
                5:
                begin
                    seq.push_back(u2c_pkg::LEAD_D1);
                    seq.push_back($urandom_range(1) ? u2c_pkg::SEC_YO_LOWER
                                                    : 8'($urandom_range(255)));
                end
                6:
                begin
                    seq.push_back(u2c_pkg::LEAD_C2);
                    case ($urandom_range(2))
                        0: seq.push_back(u2c_pkg::GUILLEMET_L);
                        1: seq.push_back(u2c_pkg::GUILLEMET_R);
                        default: seq.push_back(8'($urandom_range(255)));
                    endcase
                end
                7:
                begin
                    seq.push_back(u2c_pkg::LEAD_E2);
                    seq.push_back(u2c_pkg::SEC_E2_80);
                    seq.push_back(u2c_pkg::THIRD_DASH);
                end
                8:
                begin
                    seq.push_back(u2c_pkg::LEAD_E2);
                    seq.push_back(u2c_pkg::SEC_E2_80);
                    seq.push_back(u2c_pkg::THIRD_DOTS);
                end
                9:
                begin
                    seq.push_back(u2c_pkg::LEAD_E2);
                    seq.push_back($urandom_range(1) ? u2c_pkg::SEC_E2_80
                                                    : 8'($urandom_range(255)));
                    seq.push_back(8'($urandom_range(255)));
                end
                10:
                begin
                    seq.push_back(8'($urandom_range(255, 128)));
                    seq.push_back(8'($urandom_range(255)));
                end
                default:
                begin
                    if ($urandom_range(1))
                    begin
                        seq.push_back(8'h00);
                        seq.push_back(8'($urandom_range(255)));
                    end
                    else
                        seq.push_back(8'($urandom_range(8'h7F, 8'h01)));
                end
            endcase
        end
        // truncate mid-sequence now and then
        if ($urandom_range(7) == 0 && seq.size() > 1)
            void'(seq.pop_back());
        for (k = 0; k < seq.size(); k++)
            push_xfer(seq[k], k == seq.size() - 1);
    endtask

    task automatic gen_noise(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            push_xfer(8'($urandom_range(255)), $urandom_range(9) == 0);
        push_xfer(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned target;
        target = pushed_count + n_items;
        while (pushed_count < target)
        begin
            if ($urandom_range(9) == 0)
                gen_noise($urandom_range(12, 2));
            else
                gen_message($urandom_range(10, 1));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = u2c_pkg::REG_OUT_CAPACITY;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pushed_count   = 0;
        accepted_count = 0;
        emitted_count  = 0;
        write_count    = 0;
        err_count      = 0;
        stall_reqs     = 0;
        stall_ack      = 0;
        hold_left      = 0;
        in_taken       = 0;
        cap_reg        = u2c_pkg::CAP_RESET;
        repl_reg       = u2c_pkg::REPLACE_RESET;
        conv_phase     = u2c_pkg::PH_IDLE;
        conv_lead      = 8'h00;
        conv_second    = 8'h00;
        conv_count     = 0;
        conv_finished  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, each mapping but the right guillemet, and corners
        push_xfer(8'h41, 1'b0);
        push_xfer(8'h7F, 1'b0);
        push_xfer(u2c_pkg::LEAD_D0, 1'b0); push_xfer(8'h90, 1'b0);
        push_xfer(u2c_pkg::LEAD_D0, 1'b0); push_xfer(8'hCF, 1'b0);
        push_xfer(u2c_pkg::LEAD_D0, 1'b0); push_xfer(u2c_pkg::SEC_YO_UPPER, 1'b0);
        push_xfer(u2c_pkg::LEAD_D0, 1'b0); push_xfer(8'h41, 1'b0);
        push_xfer(u2c_pkg::LEAD_D1, 1'b0); push_xfer(8'h8F, 1'b0);
        push_xfer(u2c_pkg::LEAD_D1, 1'b0); push_xfer(u2c_pkg::SEC_YO_LOWER, 1'b0);
        push_xfer(u2c_pkg::LEAD_C2, 1'b0); push_xfer(u2c_pkg::GUILLEMET_L, 1'b0);
        push_xfer(u2c_pkg::LEAD_C2, 1'b0); push_xfer(8'h20, 1'b0);
        push_xfer(u2c_pkg::LEAD_E2, 1'b0); push_xfer(u2c_pkg::SEC_E2_80, 1'b0);
        push_xfer(u2c_pkg::THIRD_DASH, 1'b0);
        push_xfer(u2c_pkg::LEAD_E2, 1'b0); push_xfer(u2c_pkg::SEC_E2_80, 1'b0);
        push_xfer(u2c_pkg::THIRD_DOTS, 1'b0);
        push_xfer(8'hFF, 1'b0); push_xfer(8'hFF, 1'b0);
        push_xfer(8'h00, 1'b0);
        push_xfer(8'h55, 1'b0);
        push_xfer(8'hFF, 1'b1);
        push_xfer(u2c_pkg::LEAD_E2, 1'b0); push_xfer(u2c_pkg::SEC_E2_80, 1'b1);
        push_xfer(8'h00, 1'b1);
        drain();

        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'd0);
        write_reg(u2c_pkg::REG_REPLACE_CHAR, 13'h1F00);
        write_reg(REG_UNUSED, 13'h1FFF);
        gen_message(4);
        drain();
        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'd2);
        gen_message(5);
        drain();
        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'h1FFF);
        write_reg(u2c_pkg::REG_REPLACE_CHAR, 13'h00FF);
        gen_message(8);
        drain();

        // no idling, with a long output hold-off to back up the input
        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'd256);
        write_reg(u2c_pkg::REG_REPLACE_CHAR, 13'($urandom_range(255)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_reqs++;
        run_random(95);
        drain();

        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'd5);
        write_reg(u2c_pkg::REG_REPLACE_CHAR, 13'd0);
        send_idle_pct  = 48;
        recv_stall_pct = 0;
        run_random(95);
        drain();

        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'd4096);
        write_reg(u2c_pkg::REG_REPLACE_CHAR, 13'($urandom_range(8191)));
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        run_random(95);
        drain();

        write_reg(u2c_pkg::REG_OUT_CAPACITY, 13'($urandom_range(40, 1)));
        write_reg(u2c_pkg::REG_REPLACE_CHAR, 13'($urandom_range(255)));
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_random(95);
        drain();

        if (cp1251_expected.size() != 0)
        begin
            $error("%0d expected output bytes never arrived", cp1251_expected.size());
            err_count++;
        end
        $display("Run covered %0d input and %0d output transfers over %0d register writes,",
                 accepted_count, emitted_count, write_count);
        $display("capacity from zero to saturation, four idle mixes and one long output hold-off.");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
design/u2c_pkg.sv
design/u2c_decoder.sv
design/u2c_out_queue.sv
design/utf8_to_cp1251_converter.sv
test/utf8_to_cp1251_converter_test.sv
